// ===== src/rlmtf_pkg.sv =====
// ---------------------------------------------------------------------------
// rlmtf_pkg
// Shared types and codes for the recency list move-to-front unit.
// ---------------------------------------------------------------------------
package rlmtf_pkg;

	localparam int DEF_MAX_ENTRIES = 16;
	localparam int DEF_KEY_WIDTH   = 16;

	localparam logic [2:0] CMD_INS_BACK  = 3'd0;
	localparam logic [2:0] CMD_INS_FRONT = 3'd1;
	localparam logic [2:0] CMD_MOVE      = 3'd2;
	localparam logic [2:0] CMD_REM_BACK  = 3'd3;
	localparam logic [2:0] CMD_REM_KEY   = 3'd4;
	localparam logic [2:0] CMD_LOOKUP    = 3'd5;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_FEW     = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] key;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] position;
		logic [4:0] entry_count;
	} rsp_t;

endpackage

// ===== src/rlmtf_ram.sv =====
// ---------------------------------------------------------------------------
// rlmtf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rlmtf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/recency_list_move_to_front_unit.sv =====
// ---------------------------------------------------------------------------
// recency_list_move_to_front_unit
// Ordered recency list (front = most recent) kept in one RAM, with a
// sequencer that scans for keys and shifts entries one at a time.
//
//  channel  | ports              | transfer
//  command  | start, busy, req   | start high and busy low at the clock edge
//  result   | done, rsp          | done high, one cycle, cannot be held off
//
// Insert back, remove back, insert front into an empty list, ignored
// codes and errors caught without a scan: result in the next cycle.
// Scans read then compare each entry; shifts read then write each entry
// moved (one registered read port); S_PUT_FRONT places a key at the
// front. Reset empties the list at once; no clearing pass.
// ---------------------------------------------------------------------------
module recency_list_move_to_front_unit #(
	parameter int MAX_ENTRIES = rlmtf_pkg::DEF_MAX_ENTRIES,
	parameter int KEY_WIDTH   = rlmtf_pkg::DEF_KEY_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rlmtf_pkg::req_t  req,
	output logic             done,
	output rlmtf_pkg::rsp_t  rsp
);
	import rlmtf_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);
	localparam logic [CW-1:0] ONE  = CW'(1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_SHIFT_RD, S_SHIFT_WR, S_PUT_FRONT
	} state_t;

	state_t               state_q;
	logic [2:0]           cmd_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic                 down_q;
	logic                 done_q;
	rsp_t                 rsp_q;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [KEY_WIDTH-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic [KEY_WIDTH-1:0] rdata;
	logic [KEY_WIDTH-1:0] in_key;

	assign in_key = KEY_WIDTH'(req.key);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign raddr  = idx_q[AW-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = key_q;
		case (state_q)
			S_IDLE: begin
				if (start && req.command == CMD_INS_BACK && count_q < MAXC) begin
					we    = 1'b1;
					waddr = count_q[AW-1:0];
					wdata = in_key;
				end else if (start && req.command == CMD_INS_FRONT && count_q == '0) begin
					we    = 1'b1;
					wdata = in_key;
				end
			end
			S_SHIFT_WR: begin
				we    = 1'b1;
				waddr = down_q ? AW'(idx_q + ONE) : AW'(idx_q - ONE);
				wdata = rdata;
			end
			S_PUT_FRONT: begin
				we = 1'b1;
			end
			default: ;
		endcase
	end

	rlmtf_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			idx_q   <= '0;
			down_q  <= 1'b0;
			cmd_q   <= '0;
			key_q   <= '0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= req.command;
						key_q <= in_key;
						idx_q <= '0;
						rsp_q.position <= '0;
						rsp_q.status   <= ST_OK;
						rsp_q.entry_count <= 5'(count_q);
						done_q <= 1'b1;
						case (req.command)
							CMD_INS_BACK: begin
								if (count_q >= MAXC) begin
									rsp_q.status <= ST_FULL;
								end else begin
									count_q <= count_q + ONE;
									rsp_q.entry_count <= 5'(count_q + ONE);
								end
							end
							CMD_INS_FRONT: begin
								if (count_q >= MAXC) begin
									rsp_q.status <= ST_FULL;
								end else if (count_q == '0) begin
									count_q <= ONE;
									rsp_q.entry_count <= 5'(ONE);
								end else begin
									done_q  <= 1'b0;
									down_q  <= 1'b1;
									idx_q   <= count_q - ONE;
									state_q <= S_SHIFT_RD;
								end
							end
							CMD_MOVE: begin
								if (count_q < 2) begin
									rsp_q.status <= ST_FEW;
								end else begin
									done_q  <= 1'b0;
									state_q <= S_SCAN_RD;
								end
							end
							CMD_REM_BACK: begin
								if (count_q == '0) begin
									rsp_q.status <= ST_EMPTY;
								end else begin
									count_q <= count_q - ONE;
									rsp_q.entry_count <= 5'(count_q - ONE);
								end
							end
							CMD_REM_KEY: begin
								if (count_q == '0) begin
									rsp_q.status <= ST_EMPTY;
								end else begin
									done_q  <= 1'b0;
									state_q <= S_SCAN_RD;
								end
							end
							CMD_LOOKUP: begin
								if (count_q == '0) begin
									rsp_q.status <= ST_MISSING;
								end else begin
									done_q  <= 1'b0;
									state_q <= S_SCAN_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (rdata == key_q) begin
						rsp_q.position <= 4'(idx_q);
						if (cmd_q == CMD_LOOKUP || (cmd_q == CMD_MOVE && idx_q == '0)) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (cmd_q == CMD_MOVE) begin
							down_q  <= 1'b1;
							idx_q   <= idx_q - ONE;
							state_q <= S_SHIFT_RD;
						end else if (idx_q + ONE == count_q) begin
							count_q <= count_q - ONE;
							rsp_q.entry_count <= 5'(count_q - ONE);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							down_q  <= 1'b0;
							idx_q   <= idx_q + ONE;
							state_q <= S_SHIFT_RD;
						end
					end else if (idx_q + ONE == count_q) begin
						rsp_q.status <= ST_MISSING;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + ONE;
						state_q <= S_SCAN_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					if (down_q) begin
						if (idx_q == '0) begin
							state_q <= S_PUT_FRONT;
						end else begin
							idx_q   <= idx_q - ONE;
							state_q <= S_SHIFT_RD;
						end
					end else if (idx_q + ONE == count_q) begin
						count_q <= count_q - ONE;
						rsp_q.entry_count <= 5'(count_q - ONE);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + ONE;
						state_q <= S_SHIFT_RD;
					end
				end
				S_PUT_FRONT: begin
					if (cmd_q == CMD_INS_FRONT) begin
						count_q <= count_q + ONE;
						rsp_q.entry_count <= 5'(count_q + ONE);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAXC) else $error("entry count above capacity");
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.status == ST_FULL |-> count_q == MAXC)
		else $error("full reported with room left");
	a_few_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.status == ST_FEW |-> count_q < 2)
		else $error("few-entries reported with two or more entries");
	a_hit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT_WR |-> idx_q < count_q)
		else $error("shift index beyond list");
endmodule

// ===== sim/recency_list_move_to_front_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// recency_list_move_to_front_unit_test
// Drives commands into the recency list unit and checks every result against
// a behavioral copy of the list kept in the testbench.
// ---------------------------------------------------------------------------
module recency_list_move_to_front_unit_test;
	import rlmtf_pkg::*;

	localparam int DEPTH = DEF_MAX_ENTRIES;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	logic [15:0] list_keys[DEPTH];
	int list_len;
	rsp_t pending_rsp[$];
	int error_count = 0;
	int idle_cycles = 0;

	recency_list_move_to_front_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int find_key(logic [15:0] k);
		for (int i = 0; i < list_len; i++)
			if (list_keys[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void drop_at(int p);
		for (int i = p; i + 1 < list_len; i++)
			list_keys[i] = list_keys[i + 1];
		list_len--;
	endfunction

	function automatic void push_front(logic [15:0] k);
		for (int i = list_len; i > 0; i--)
			list_keys[i] = list_keys[i - 1];
		list_keys[0] = k;
		list_len++;
	endfunction

	function automatic rsp_t apply_command(req_t r);
		rsp_t o;
		int hit;
		o.status = ST_OK;
		o.position = '0;
		case (r.command)
			CMD_INS_BACK: begin
				if (list_len >= DEPTH) o.status = ST_FULL;
				else begin
					list_keys[list_len] = r.key;
					list_len++;
				end
			end
			CMD_INS_FRONT: begin
				if (list_len >= DEPTH) o.status = ST_FULL;
				else push_front(r.key);
			end
			CMD_MOVE: begin
				if (list_len < 2) o.status = ST_FEW;
				else begin
					hit = find_key(r.key);
					if (hit < 0) o.status = ST_MISSING;
					else begin
						o.position = hit[3:0];
						drop_at(hit);
						push_front(r.key);
					end
				end
			end
			CMD_REM_BACK: begin
				if (list_len == 0) o.status = ST_EMPTY;
				else list_len--;
			end
			CMD_REM_KEY: begin
				if (list_len == 0) o.status = ST_EMPTY;
				else begin
					hit = find_key(r.key);
					if (hit < 0) o.status = ST_MISSING;
					else begin
						o.position = hit[3:0];
						drop_at(hit);
					end
				end
			end
			CMD_LOOKUP: begin
				hit = find_key(r.key);
				if (hit < 0) o.status = ST_MISSING;
				else o.position = hit[3:0];
			end
			default: ;
		endcase
		o.entry_count = list_len[4:0];
		return o;
	endfunction

	// one command transfer, after a random gap
	task automatic send_command(logic [2:0] c, logic [15:0] k);
		req_t r;
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.command = c;
		r.key = k;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		pending_rsp.push_back(apply_command(r));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					$display("%t unexpected result %p", $time, rsp);
					error_count++;
				end else begin
					rsp_t e;
					e = pending_rsp.pop_front();
					if (rsp.status !== e.status)
						$display("%t status exp %0d got %0d", $time, e.status,
							rsp.status);
					if (rsp.position !== e.position)
						$display("%t position exp %0d got %0d", $time, e.position,
							rsp.position);
					if (rsp.entry_count !== e.entry_count)
						$display("%t entry_count exp %0d got %0d", $time,
							e.entry_count, rsp.entry_count);
					if (rsp !== e) error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// key drawn mostly from the keys held, to get hits
	function automatic logic [15:0] pick_key();
		if (list_len > 0 && $urandom_range(0, 2) != 0)
			return list_keys[$urandom_range(0, list_len - 1)];
		if ($urandom_range(0, 1) == 0)
			return 16'($urandom_range(0, 7));
		return 16'($urandom);
	endfunction

	task automatic test_empty_list();
		send_command(CMD_REM_BACK, 16'h0000);
		send_command(CMD_REM_KEY, 16'hFFFF);
		send_command(CMD_LOOKUP, 16'h0000);
		send_command(CMD_MOVE, 16'h0000);
		send_command(3'd6, 16'h1234);
		send_command(3'd7, 16'hFFFF);
	endtask

	task automatic test_fill_and_full();
		send_command(CMD_INS_BACK, 16'hFFFF);
		send_command(CMD_MOVE, 16'hFFFF);
		for (int i = 1; i < DEPTH; i++)
			send_command(i[0] ? CMD_INS_FRONT : CMD_INS_BACK, 16'(i * 16'h1111));
		send_command(CMD_INS_BACK, 16'h0001);
		send_command(CMD_INS_FRONT, 16'h0002);
	endtask

	task automatic test_hits();
		send_command(CMD_LOOKUP, list_keys[DEPTH - 1]);
		send_command(CMD_MOVE, list_keys[0]);
		send_command(CMD_MOVE, list_keys[DEPTH - 1]);
		send_command(CMD_MOVE, 16'hABCD);
		send_command(CMD_REM_KEY, list_keys[DEPTH - 1]);
		send_command(CMD_REM_KEY, 16'hABCD);
		send_command(CMD_INS_FRONT, list_keys[3]);
		send_command(CMD_LOOKUP, list_keys[0]);
	endtask

	task automatic test_random_mix();
		logic [2:0] c;
		for (int n = 0; n < 1750; n++) begin
			case ($urandom_range(0, 19))
				0, 1, 2: c = CMD_INS_BACK;
				3, 4, 5: c = CMD_INS_FRONT;
				6, 7, 8, 9: c = CMD_MOVE;
				10, 11: c = CMD_REM_BACK;
				12, 13, 14: c = CMD_REM_KEY;
				15, 16, 17: c = CMD_LOOKUP;
				default: c = 3'($urandom_range(0, 7));
			endcase
			send_command(c, pick_key());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		list_len = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_and_full();
		test_hits();
		test_random_mix();
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4 * DEPTH + 10) @(posedge clk);
		if (error_count == 0 && pending_rsp.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
